// ===== rtl/pgsr_pkg.sv =====
// ----------------------------------------------------------------------------
// Pointer gesture stroke recognizer - shared definitions
// Event codes, result kinds, button codes and the sector boundary constants.
// ----------------------------------------------------------------------------
package pgsr_pkg;

    typedef enum logic [2:0] {
        ACT_PRESS    = 3'd0,
        ACT_DBLCLICK = 3'd1,
        ACT_RELEASE  = 3'd2,
        ACT_MOVE     = 3'd3,
        ACT_WHEEL    = 3'd4,
        ACT_CANCEL   = 3'd5
    } action_t;

    typedef enum logic {
        KIND_UPDATE = 1'b0,
        KIND_FINISH = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        DIR_E = 2'd0,
        DIR_S = 2'd1,
        DIR_W = 2'd2,
        DIR_N = 2'd3
    } dir_t;

    localparam logic [4:0]  BTN_WHEEL_UP   = 5'd16;
    localparam logic [4:0]  BTN_WHEEL_DOWN = 5'd17;

    localparam logic [31:0] THRESHOLD_SQ_RESET = 32'd2500;

    // sin and cos of 46 degrees, fixed point with a common scale
    localparam logic signed [65:0] SIN46_FX = 66'sd71933980033865;
    localparam logic signed [65:0] COS46_FX = 66'sd69465837045900;

    localparam int unsigned S_DATA_W = 88;
    localparam int unsigned S_USER_W = 3;
    localparam int unsigned M_DATA_W = 160;
    localparam int unsigned M_USER_W = 1;

endpackage

// ===== rtl/pointer_gesture_stroke_recognizer.sv =====
// ----------------------------------------------------------------------------
// Pointer gesture stroke recognizer
// Tracks held buttons, kept points and a quantized E/S/W/N direction path
// from a stream of pointer events, and emits update and finish results.
//
//  channel  | direction | handshake          | content
//  s_       | in        | s_tvalid/s_tready  | one pointer event
//  m_       | out       | m_tvalid/m_tready  | zero or one result per event
//  cfg_     | in        | cfg_we             | move threshold, no read-back
//
//  An event is registered on acceptance and evaluated from the input stage
//  once the result stage can advance; its result is registered in the result
//  stage in that evaluation step and is then offered on m_tvalid.
//  One event per cycle is sustained while results are taken; the gesture state
//  is updated in the evaluation step. A held result stalls the evaluation stage
//  and, through it, s_tready. Reset clears the gesture state and sets the threshold to 50.
// ----------------------------------------------------------------------------
module pointer_gesture_stroke_recognizer #(
    parameter int unsigned MAX_DIRECTIONS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_tvalid,
    output logic                           s_tready,
    // pos_x[15:0], pos_y[31:16], button_code[35:32], modifiers[39:36],
    // wheel_delta[55:40], time_ms[87:56]
    input  logic [pgsr_pkg::S_DATA_W-1:0]  s_tdata,
    // action[2:0]
    input  logic [pgsr_pkg::S_USER_W-1:0]  s_tuser,

    output logic                           m_tvalid,
    input  logic                           m_tready,
    // button_out[4:0], path_bits[36:5], path_length[41:37], path_full[42],
    // start_x[58:43], start_y[74:59], end_x[90:75], end_y[106:91],
    // duration_ms[138:107], wheel_out[154:139], modifiers_out[158:155]
    output logic [pgsr_pkg::M_DATA_W-1:0]  m_tdata,
    // kind[0]
    output logic [pgsr_pkg::M_USER_W-1:0]  m_tuser,

    input  logic                           cfg_we,
    input  logic [15:0]                    cfg_wdata
);

    import pgsr_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_DIRECTIONS + 1);

    // input stage
    logic               in_valid_reg;
    logic [2:0]         in_action_reg;
    logic signed [15:0] in_pos_x_reg;
    logic signed [15:0] in_pos_y_reg;
    logic [3:0]         in_button_reg;
    logic [3:0]         in_mods_reg;
    logic signed [15:0] in_wheel_reg;
    logic [31:0]        in_time_reg;

    // gesture state
    logic [31:0]        threshold_sq_reg;
    logic               detecting_reg,  detecting_next;
    logic [3:0]         held_reg,       held_next;
    logic [CNT_W-1:0]   count_reg,      count_next;
    logic               overflow_reg,   overflow_next;
    logic [31:0]        path_reg,       path_next;
    logic [1:0]         last_dir_reg,   last_dir_next;
    logic signed [15:0] first_x_reg,    first_x_next;
    logic signed [15:0] first_y_reg,    first_y_next;
    logic signed [15:0] last_x_reg,     last_x_next;
    logic signed [15:0] last_y_reg,     last_y_next;
    logic [31:0]        start_time_reg, start_time_next;
    logic [4:0]         gbutton_reg,    gbutton_next;

    // result stage
    logic                 out_valid_reg;
    logic [M_DATA_W-1:0]  out_data_reg;
    logic                 out_kind_reg;

    logic                 advance;
    logic                 step;

    logic signed [16:0]   dx;
    logic signed [16:0]   dy;
    logic signed [33:0]   sq_x;
    logic signed [33:0]   sq_y;
    logic [32:0]          dist_sq;
    logic                 far_enough;
    logic signed [17:0]   dx_plus_dy;
    logic signed [17:0]   dx_minus_dy;
    logic signed [65:0]   cross_e;
    logic signed [65:0]   cross_s;
    logic [1:0]           dir;

    logic                 res_valid;
    logic                 res_kind;
    logic [31:0]          res_dur;
    logic signed [15:0]   res_wheel;
    logic [5:0]           count_ext;
    logic [4:0]           res_length;
    logic [31:0]          res_path;
    logic                 res_full;
    logic                 appended;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign step     = in_valid_reg && advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;

    // step geometry
    assign dx   = 17'(in_pos_x_reg) - 17'(last_x_reg);
    assign dy   = 17'(in_pos_y_reg) - 17'(last_y_reg);
    assign sq_x = 34'(dx) * 34'(dx);
    assign sq_y = 34'(dy) * 34'(dy);
    assign dist_sq    = {1'b0, sq_x[31:0]} + {1'b0, sq_y[31:0]};
    assign far_enough = dist_sq > {1'b0, threshold_sq_reg};

    assign dx_plus_dy  = 18'(dx) + 18'(dy);
    assign dx_minus_dy = 18'(dx) - 18'(dy);
    assign cross_e     = 66'(dx) * SIN46_FX - 66'(dy) * COS46_FX;
    assign cross_s     = 66'(dy) * SIN46_FX + 66'(dx) * COS46_FX;

    always_comb begin
        if (dx_plus_dy > 18'sd0 && cross_e > 66'sd0) begin
            dir = DIR_E;
        end else if (cross_e < 66'sd0 && cross_s > 66'sd0) begin
            dir = DIR_S;
        end else if (dx_minus_dy > 18'sd0 && dx_plus_dy <= 18'sd0) begin
            dir = DIR_N;
        end else begin
            dir = DIR_W;
        end
    end

    // event evaluation
    always_comb begin
        detecting_next  = detecting_reg;
        held_next       = held_reg;
        count_next      = count_reg;
        overflow_next   = overflow_reg;
        path_next       = path_reg;
        last_dir_next   = last_dir_reg;
        first_x_next    = first_x_reg;
        first_y_next    = first_y_reg;
        last_x_next     = last_x_reg;
        last_y_next     = last_y_reg;
        start_time_next = start_time_reg;
        gbutton_next    = gbutton_reg;
        res_valid       = 1'b0;
        res_kind        = KIND_UPDATE;
        res_dur         = in_time_reg - start_time_reg;
        res_wheel       = '0;
        appended        = 1'b0;
        count_ext       = 6'(count_reg);

        if (in_action_reg > ACT_CANCEL) begin
            // drop unknown events
        end else if (in_action_reg == ACT_CANCEL) begin
            count_next     = '0;
            overflow_next  = 1'b0;
            path_next      = '0;
            detecting_next = 1'b0;
            gbutton_next   = '0;
            held_next      = '0;
        end else if (in_action_reg == ACT_RELEASE && held_reg > 4'd1) begin
            held_next = held_reg - 4'd1;
        end else if (in_action_reg == ACT_MOVE && (!detecting_reg || held_reg == 4'd0)) begin
            // ignore moves outside a gesture or without a held button
        end else begin
            if (in_action_reg == ACT_PRESS && held_reg != 4'd15) begin
                held_next = held_reg + 4'd1;
            end else if (in_action_reg == ACT_RELEASE && held_reg != 4'd0) begin
                held_next = held_reg - 4'd1;
            end

            if (in_action_reg == ACT_WHEEL) begin
                count_next      = '0;
                overflow_next   = 1'b0;
                path_next       = '0;
                first_x_next    = in_pos_x_reg;
                last_x_next     = in_pos_x_reg;
                first_y_next    = in_pos_y_reg;
                last_y_next     = in_pos_y_reg;
                start_time_next = in_time_reg;
                gbutton_next    = (in_wheel_reg > 16'sd0) ? BTN_WHEEL_UP : BTN_WHEEL_DOWN;
                detecting_next  = 1'b0;
                res_valid       = 1'b1;
                res_kind        = KIND_FINISH;
                res_dur         = '0;
                res_wheel       = in_wheel_reg;
            end else if (!detecting_reg) begin
                detecting_next  = 1'b1;
                count_next      = '0;
                overflow_next   = 1'b0;
                path_next       = '0;
                first_x_next    = in_pos_x_reg;
                last_x_next     = in_pos_x_reg;
                first_y_next    = in_pos_y_reg;
                last_y_next     = in_pos_y_reg;
                start_time_next = in_time_reg;
                gbutton_next    = {1'b0, in_button_reg};
            end else if (in_action_reg == ACT_RELEASE) begin
                detecting_next = 1'b0;
                res_valid      = 1'b1;
                res_kind       = KIND_FINISH;
            end else if (far_enough) begin
                if (count_reg == '0 || last_dir_reg != dir) begin
                    if (count_reg < CNT_W'(MAX_DIRECTIONS)) begin
                        if (count_ext < 6'd16) begin
                            path_next[{count_ext[3:0], 1'b0} +: 2] = dir;
                        end
                        count_next    = count_reg + 1'b1;
                        last_dir_next = dir;
                        appended      = 1'b1;
                    end else begin
                        overflow_next = 1'b1;
                    end
                end
                last_x_next = in_pos_x_reg;
                last_y_next = in_pos_y_reg;
                res_valid   = appended || count_next == CNT_W'(1);
            end
        end

        count_ext  = 6'(count_next);
        res_length = (count_ext > 6'd31) ? 5'd31 : count_ext[4:0];
        res_path   = path_next;
        res_full   = overflow_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            threshold_sq_reg <= THRESHOLD_SQ_RESET;
            detecting_reg    <= 1'b0;
            held_reg         <= '0;
            count_reg        <= '0;
            overflow_reg     <= 1'b0;
            path_reg         <= '0;
            last_dir_reg     <= DIR_E;
            first_x_reg      <= '0;
            first_y_reg      <= '0;
            last_x_reg       <= '0;
            last_y_reg       <= '0;
            start_time_reg   <= '0;
            gbutton_reg      <= '0;
        end else begin
            if (cfg_we) begin
                threshold_sq_reg <= 32'(cfg_wdata) * 32'(cfg_wdata);
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= step && res_valid;
            end
            if (step) begin
                detecting_reg  <= detecting_next;
                held_reg       <= held_next;
                count_reg      <= count_next;
                overflow_reg   <= overflow_next;
                path_reg       <= path_next;
                last_dir_reg   <= last_dir_next;
                first_x_reg    <= first_x_next;
                first_y_reg    <= first_y_next;
                last_x_reg     <= last_x_next;
                last_y_reg     <= last_y_next;
                start_time_reg <= start_time_next;
                gbutton_reg    <= gbutton_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_action_reg <= s_tuser[2:0];
            in_pos_x_reg  <= s_tdata[15:0];
            in_pos_y_reg  <= s_tdata[31:16];
            in_button_reg <= s_tdata[35:32];
            in_mods_reg   <= s_tdata[39:36];
            in_wheel_reg  <= s_tdata[55:40];
            in_time_reg   <= s_tdata[87:56];
        end
        if (step && res_valid) begin
            out_kind_reg <= res_kind;
            out_data_reg <= {1'b0, in_mods_reg, res_wheel, res_dur,
                             last_y_next, last_x_next, first_y_next, first_x_next,
                             res_full, res_length, res_path, gbutton_next};
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_DIRECTIONS))
        else $error("direction count beyond path capacity");

    assert property (@(posedge aclk) disable iff (!aresetn)
        overflow_reg |-> count_reg == CNT_W'(MAX_DIRECTIONS))
        else $error("path full flag set while path has room");

    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0] == KIND_FINISH && m_tdata[4:0] == BTN_WHEEL_UP)
        |-> m_tdata[41:37] == 5'd0)
        else $error("wheel finish carries a path");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (step && res_valid && res_kind == KIND_UPDATE) |-> detecting_next)
        else $error("update result outside a gesture");

endmodule

// ===== test/pgsr_gesture_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gesture stroke checker
// Watches the event, result and threshold ports of the stroke recognizer,
// predicts every update and finish result from its own copy of the gesture
// state, and compares each result transaction field by field, in order.
// ----------------------------------------------------------------------------
module pgsr_gesture_checker #(
    parameter int unsigned MAX_DIRS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [pgsr_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic [pgsr_pkg::S_USER_W-1:0]  s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [pgsr_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic [pgsr_pkg::M_USER_W-1:0]  m_tuser,
    input  logic                           cfg_we,
    input  logic [15:0]                    cfg_wdata,
    output int unsigned                    mismatches,
    output int unsigned                    pending
);
    import pgsr_pkg::*;

    typedef struct {
        kind_t              kind;
        logic [4:0]         button;
        logic [31:0]        path;
        logic [4:0]         length;
        logic               full;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic [31:0]        duration;
        logic signed [15:0] wheel;
        logic [3:0]         mods;
    } gesture_report_t;

    gesture_report_t awaited_reports[$];

    logic [15:0]        threshold;
    logic               tracking;
    logic [3:0]         buttons_down;
    dir_t               stroke_dirs[MAX_DIRS];
    int                 stroke_len;
    logic               stroke_dropped;
    logic signed [15:0] anchor_x, anchor_y, kept_x, kept_y;
    logic [31:0]        t_start;
    logic [4:0]         owner_button;

    function automatic dir_t quantize(input longint dx, input longint dy);
        logic signed [95:0] cos_dy, sin_dx, sin_dy, cos_dx;
        cos_dy = COS46_FX * dy;
        sin_dx = SIN46_FX * dx;
        sin_dy = SIN46_FX * dy;
        cos_dx = COS46_FX * dx;
        if (dx + dy > 0 && cos_dy < sin_dx)
            return DIR_E;
        if (cos_dy > sin_dx && sin_dy > -cos_dx)
            return DIR_S;
        if (dx - dy > 0 && dx + dy <= 0)
            return DIR_N;
        return DIR_W;
    endfunction

    function automatic gesture_report_t make_report(input kind_t k, input logic [31:0] dur,
                                                    input logic signed [15:0] whl,
                                                    input logic [3:0] mods);
        gesture_report_t r;
        int i;
        r.kind   = k;
        r.button = owner_button;
        r.path   = '0;
        for (i = 0; i < 16 && i < int'(MAX_DIRS); i++)
            if (i < stroke_len)
                r.path[2*i +: 2] = stroke_dirs[i];
        r.length   = (stroke_len > 31) ? 5'd31 : 5'(stroke_len);
        r.full     = stroke_dropped;
        r.start_x  = anchor_x;
        r.start_y  = anchor_y;
        r.end_x    = kept_x;
        r.end_y    = kept_y;
        r.duration = dur;
        r.wheel    = whl;
        r.mods     = mods;
        return r;
    endfunction

    task automatic reset_state();
        int i;
        threshold      = 16'd50;
        tracking       = 1'b0;
        buttons_down   = '0;
        for (i = 0; i < int'(MAX_DIRS); i++)
            stroke_dirs[i] = DIR_E;
        stroke_len     = 0;
        stroke_dropped = 1'b0;
        anchor_x = '0; anchor_y = '0; kept_x = '0; kept_y = '0;
        t_start        = '0;
        owner_button   = '0;
    endtask

    task automatic apply_event(input logic [2:0] act, input logic signed [15:0] px, py,
                               input logic [3:0] btn, mods, input logic signed [15:0] whl,
                               input logic [31:0] now, output bit emits,
                               output gesture_report_t rep);
        longint dx, dy, d2, t2;
        dir_t   d;
        bit     grew;
        emits = 1'b0;
        if (act > ACT_CANCEL)
            return;
        if (act == ACT_CANCEL) begin
            stroke_len     = 0;
            stroke_dropped = 1'b0;
            tracking       = 1'b0;
            owner_button   = '0;
            buttons_down   = '0;
            return;
        end
        if (act == ACT_RELEASE && buttons_down > 1) begin
            buttons_down--;
            return;
        end
        if (act == ACT_MOVE && (!tracking || buttons_down == 0))
            return;
        if (act == ACT_PRESS) begin
            if (buttons_down != 4'd15)
                buttons_down++;
        end else if (act == ACT_RELEASE) begin
            if (buttons_down != 4'd0)
                buttons_down--;
        end

        if (act == ACT_WHEEL) begin
            stroke_len     = 0;
            stroke_dropped = 1'b0;
            anchor_x = px; kept_x = px;
            anchor_y = py; kept_y = py;
            t_start        = now;
            owner_button   = (whl > 0) ? BTN_WHEEL_UP : BTN_WHEEL_DOWN;
            rep            = make_report(KIND_FINISH, '0, whl, mods);
            emits          = 1'b1;
            tracking       = 1'b0;
            return;
        end

        if (!tracking) begin
            tracking       = 1'b1;
            stroke_len     = 0;
            stroke_dropped = 1'b0;
            anchor_x = px; kept_x = px;
            anchor_y = py; kept_y = py;
            t_start        = now;
            owner_button   = {1'b0, btn};
            return;
        end

        if (act == ACT_RELEASE) begin
            rep      = make_report(KIND_FINISH, now - t_start, '0, mods);
            emits    = 1'b1;
            tracking = 1'b0;
            return;
        end

        dx = longint'(px) - longint'(kept_x);
        dy = longint'(py) - longint'(kept_y);
        d2 = dx * dx + dy * dy;
        t2 = longint'(threshold) * longint'(threshold);
        if (d2 <= t2)
            return;
        d    = quantize(dx, dy);
        grew = 1'b0;
        if (stroke_len == 0 || stroke_dirs[stroke_len - 1] != d) begin
            if (stroke_len < int'(MAX_DIRS)) begin
                stroke_dirs[stroke_len] = d;
                stroke_len++;
                grew = 1'b1;
            end else begin
                stroke_dropped = 1'b1;
            end
        end
        kept_x = px;
        kept_y = py;
        if (grew || stroke_len == 1) begin
            rep   = make_report(KIND_UPDATE, now - t_start, '0, mods);
            emits = 1'b1;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want, got,
                               inout bit bad);
        if (want !== got) begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
            bad = 1'b1;
        end
    endtask

    task automatic compare_report(input gesture_report_t want);
        gesture_report_t got;
        bit bad;
        bad          = 1'b0;
        got.kind     = kind_t'(m_tuser[0]);
        got.button   = m_tdata[4:0];
        got.path     = m_tdata[36:5];
        got.length   = m_tdata[41:37];
        got.full     = m_tdata[42];
        got.start_x  = m_tdata[58:43];
        got.start_y  = m_tdata[74:59];
        got.end_x    = m_tdata[90:75];
        got.end_y    = m_tdata[106:91];
        got.duration = m_tdata[138:107];
        got.wheel    = m_tdata[154:139];
        got.mods     = m_tdata[158:155];
        check_field("kind",          want.kind,     got.kind,     bad);
        check_field("button_out",    want.button,   got.button,   bad);
        check_field("path_bits",     want.path,     got.path,     bad);
        check_field("path_length",   want.length,   got.length,   bad);
        check_field("path_full",     want.full,     got.full,     bad);
        check_field("start_x",       want.start_x,  got.start_x,  bad);
        check_field("start_y",       want.start_y,  got.start_y,  bad);
        check_field("end_x",         want.end_x,    got.end_x,    bad);
        check_field("end_y",         want.end_y,    got.end_y,    bad);
        check_field("duration_ms",   want.duration, got.duration, bad);
        check_field("wheel_out",     want.wheel,    got.wheel,    bad);
        check_field("modifiers_out", want.mods,     got.mods,     bad);
        if (bad)
            mismatches++;
    endtask

    initial begin
        mismatches = 0;
        pending    = 0;
        reset_state();
    end

    always @(posedge aclk) begin
        gesture_report_t rep;
        bit emits;
        if (!aresetn) begin
            reset_state();
            awaited_reports.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (awaited_reports.size() == 0) begin
                    $display("%0t: result transaction with none expected, got 0x%0h",
                             $time, m_tdata);
                    mismatches++;
                end else begin
                    compare_report(awaited_reports.pop_front());
                end
            end
            if (cfg_we)
                threshold = cfg_wdata;
            if (s_tvalid && s_tready) begin
                apply_event(s_tuser, s_tdata[15:0], s_tdata[31:16], s_tdata[35:32],
                            s_tdata[39:36], s_tdata[55:40], s_tdata[87:56], emits, rep);
                if (emits)
                    awaited_reports.push_back(rep);
            end
        end
        pending = awaited_reports.size();
    end

endmodule

// ===== test/tb_pointer_gesture_stroke_recognizer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stroke recognizer testbench
// Drives directed and random pointer event sequences (strokes, zigzags,
// button floods, wheel, cancel and noise) under several thresholds and
// handshake idling patterns; the checker predicts and compares all results.
// ----------------------------------------------------------------------------
module tb_pointer_gesture_stroke_recognizer;
    import pgsr_pkg::*;

    localparam int unsigned MAX_DIRS    = 16;
    localparam int          HOLD_CYCLES = 400;
    localparam logic [2:0]  ACT_RESERVED_6 = 3'd6;
    localparam logic [2:0]  ACT_RESERVED_7 = 3'd7;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata   = '0;
    logic [S_USER_W-1:0]  s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic [M_USER_W-1:0]  m_tuser;
    logic                 cfg_we    = 1'b0;
    logic [15:0]          cfg_wdata = '0;

    int unsigned mismatches, pending;
    int          gap_pct = 0, stall_pct = 0;
    int          hold_token = 0, hold_seen = 0;
    int          threshold_now = 50;
    int          cur_x = 0, cur_y = 0;
    logic [31:0] clock_ms;
    int          items_sent = 0;

    pointer_gesture_stroke_recognizer #(.MAX_DIRECTIONS(MAX_DIRS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    pgsr_gesture_checker #(.MAX_DIRS(MAX_DIRS)) u_gesture_check (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .mismatches(mismatches), .pending(pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #3_000_000;
        $display("pointer_gesture_stroke_recognizer: mismatch");
        $finish;
    end

    // result side: random stalls, with one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic int clamp16(input int v);
        return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    endfunction

    task automatic send_event(input logic [2:0] act, input int x, y, input logic [3:0] btn,
                              mods, input int whl, input logic [31:0] stamp);
        while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {stamp, whl[15:0], mods, btn, y[15:0], x[15:0]};
        do @(posedge aclk); while (!s_tready);
        if (act <= ACT_CANCEL)
            items_sent++;
    endtask

    task automatic emit(input logic [2:0] act, input logic [3:0] btn);
        clock_ms += $urandom_range(300);
        send_event(act, cur_x, cur_y, btn, 4'($urandom), int'($urandom), clock_ms);
    endtask

    task automatic start_point();
        if ($urandom_range(5) == 0) begin
            cur_x = int'($urandom_range(65535)) - 32768;
            cur_y = int'($urandom_range(65535)) - 32768;
        end else begin
            cur_x = int'($urandom_range(40000)) - 20000;
            cur_y = int'($urandom_range(40000)) - 20000;
        end
    endtask

    task automatic take_step(input dir_t d);
        int mag, side, sx, sy;
        if (threshold_now > 16000)
            mag = int'($urandom_range(65535, 40000));
        else if ($urandom_range(7) == 0)
            mag = int'($urandom_range(threshold_now));
        else
            mag = threshold_now + 1 + int'($urandom_range(threshold_now + 30));
        side = (mag == 0) ? 0 : int'($urandom_range(2 * mag)) - mag;
        // lean onto a sector boundary now and then
        if ($urandom_range(5) == 0)
            side = ($urandom_range(1) ? mag : -mag) + int'($urandom_range(2)) - 1;
        case (d)
            DIR_E: begin
                sx = mag;  sy = side;
            end
            DIR_S: begin
                sx = side; sy = mag;
            end
            DIR_W: begin
                sx = -mag; sy = side;
            end
            default: begin
                sx = side; sy = -mag;
            end
        endcase
        cur_x = clamp16(cur_x + sx);
        cur_y = clamp16(cur_y + sy);
    endtask

    task automatic ordinary_stroke();
        logic [3:0] btn;
        int presses, k;
        btn     = 4'($urandom);
        presses = 1;
        start_point();
        emit(ACT_PRESS, btn);
        repeat ($urandom_range(10, 1)) begin
            k = int'($urandom_range(19));
            take_step(dir_t'($urandom_range(3)));
            if (k == 0) begin
                emit(ACT_PRESS, 4'($urandom));
                presses++;
            end else if (k == 1) begin
                emit(ACT_DBLCLICK, btn);
            end else if (k == 2 && presses > 1) begin
                emit(ACT_RELEASE, btn);
                presses--;
            end else begin
                emit(ACT_MOVE, btn);
            end
        end
        repeat (presses) emit(ACT_RELEASE, btn);
    endtask

    task automatic zigzag_stroke();
        logic [3:0] btn;
        dir_t a, b;
        int i;
        btn = 4'($urandom);
        a   = dir_t'($urandom_range(3));
        b   = dir_t'(a + 2'($urandom_range(3, 1)));
        cur_x = int'($urandom_range(4000)) - 2000;
        cur_y = int'($urandom_range(4000)) - 2000;
        emit(ACT_PRESS, btn);
        for (i = 0; i < int'($urandom_range(22, 17)); i++) begin
            take_step((i % 2 == 0) ? a : b);
            emit(ACT_MOVE, btn);
        end
        emit(ACT_RELEASE, btn);
    endtask

    task automatic press_flood();
        logic [3:0] btn;
        btn = 4'($urandom);
        start_point();
        repeat ($urandom_range(18, 14)) emit(ACT_PRESS, btn);
        repeat ($urandom_range(3)) begin
            take_step(dir_t'($urandom_range(3)));
            emit(ACT_MOVE, btn);
        end
        repeat ($urandom_range(18, 14)) emit(ACT_RELEASE, btn);
    endtask

    task automatic wheel_event();
        logic [3:0] btn;
        int whl;
        btn = 4'($urandom);
        start_point();
        if ($urandom_range(1)) begin
            emit(ACT_PRESS, btn);
            take_step(dir_t'($urandom_range(3)));
            emit(ACT_MOVE, btn);
        end
        whl = ($urandom_range(3) == 0) ? 0 : int'($urandom);
        clock_ms += $urandom_range(300);
        send_event(ACT_WHEEL, cur_x, cur_y, btn, 4'($urandom), whl, clock_ms);
    endtask

    task automatic cancelled_stroke();
        logic [3:0] btn;
        btn = 4'($urandom);
        start_point();
        emit(ACT_PRESS, btn);
        repeat ($urandom_range(5)) begin
            take_step(dir_t'($urandom_range(3)));
            emit(ACT_MOVE, btn);
        end
        emit(ACT_CANCEL, btn);
    endtask

    task automatic noise_burst();
        logic [2:0] act;
        repeat ($urandom_range(4, 1)) begin
            if ($urandom_range(19) == 0)
                act = $urandom_range(1) ? ACT_RESERVED_6 : ACT_RESERVED_7;
            else
                act = 3'($urandom_range(5));
            cur_x = int'($urandom_range(65535)) - 32768;
            cur_y = int'($urandom_range(65535)) - 32768;
            send_event(act, cur_x, cur_y, 4'($urandom), 4'($urandom), int'($urandom),
                       $urandom);
        end
    endtask

    task automatic random_phase(input int count);
        int target, r;
        target = items_sent + count;
        while (items_sent < target) begin
            r = int'($urandom_range(99));
            if (r < 55)
                ordinary_stroke();
            else if (r < 63)
                zigzag_stroke();
            else if (r < 68)
                press_flood();
            else if (r < 76)
                wheel_event();
            else if (r < 84)
                cancelled_stroke();
            else
                noise_burst();
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_threshold(input logic [15:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        threshold_now = v;
    endtask

    task automatic directed_events();
        send_event(ACT_MOVE,       0,      0,      4'h3, 4'h0, 0,      32'd0);
        send_event(ACT_RELEASE,    -32768, -32768, 4'hF, 4'hF, 32767,  32'hFFFF_FFF0);
        send_event(ACT_PRESS,      0,      0,      4'h0, 4'h0, -32768, 32'h0000_0010);
        send_event(ACT_MOVE,       32767,  0,      4'h0, 4'h1, 0,      32'd20);
        send_event(ACT_MOVE,       32667,  100,    4'h0, 4'h2, 0,      32'd30);
        send_event(ACT_MOVE,       32567,  0,      4'h0, 4'h4, 0,      32'd40);
        send_event(ACT_MOVE,       32667,  -100,   4'h0, 4'h8, 0,      32'd50);
        send_event(ACT_MOVE,       32767,  0,      4'h0, 4'h0, 0,      32'd60);
        send_event(ACT_MOVE,       32757,  -10,    4'h0, 4'h0, 0,      32'd70);
        send_event(ACT_DBLCLICK,   32757,  60,     4'h0, 4'h0, 0,      32'd80);
        send_event(ACT_PRESS,      32697,  60,     4'h9, 4'h0, 0,      32'd90);
        send_event(ACT_RELEASE,    32697,  60,     4'h9, 4'h0, 0,      32'd100);
        send_event(ACT_RELEASE,    32697,  60,     4'h0, 4'hF, 0,      32'd110);
        send_event(ACT_WHEEL,      32767,  32767,  4'h1, 4'h5, 0,      32'd120);
        send_event(ACT_WHEEL,      -32768, 32767,  4'h2, 4'hA, 32767,  32'd130);
        send_event(ACT_WHEEL,      0,      0,      4'h3, 4'h0, -32768, 32'd140);
        send_event(ACT_PRESS,      100,    -200,   4'h5, 4'h0, 0,      32'd150);
        send_event(ACT_MOVE,       300,    -200,   4'h5, 4'h3, 0,      32'd160);
        send_event(ACT_CANCEL,     300,    -200,   4'h5, 4'h0, 0,      32'd170);
        send_event(ACT_MOVE,       0,      0,      4'h5, 4'h0, 0,      32'd180);
        send_event(ACT_RESERVED_6, 1,      1,      4'h1, 4'h1, 1,      32'd190);
        send_event(ACT_RESERVED_7, -1,     -1,     4'hE, 4'hE, -1,     32'd200);
        send_event(ACT_PRESS,      5,      5,      4'hC, 4'h0, 0,      32'hFFFF_FFFF);
        send_event(ACT_RELEASE,    5,      5,      4'hC, 4'h6, 0,      32'd0);
    endtask

    initial begin
        clock_ms = $urandom;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed_events();
        random_phase(150);

        set_threshold(16'd0);
        gap_pct = 77;
        random_phase(120);

        gap_pct = 0;
        set_threshold(16'hFFFF);
        stall_pct = 77;
        random_phase(60);

        set_threshold(16'd3);
        gap_pct   = 29;
        stall_pct = 29;
        random_phase(150);

        set_threshold(16'($urandom_range(2000, 1)));
        gap_pct   = 0;
        stall_pct = 0;
        hold_token++;
        random_phase(150);

        set_threshold(16'($urandom_range(300, 4)));
        gap_pct   = 29;
        stall_pct = 29;
        random_phase(120);

        drain();
        repeat (20) @(posedge aclk);
        if (mismatches == 0)
            $display("pointer_gesture_stroke_recognizer: match");
        else
            $display("pointer_gesture_stroke_recognizer: mismatch");
        $finish;
    end

endmodule
